/* rtl/core/micgs_pkg.sv */
// ----------------------------------------------------------------------------
// micgs_pkg
// Types, register indexes and constants for the microphone sample
// conditioning block with gain, saturation and silence stop.
// ----------------------------------------------------------------------------
package micgs_pkg;

  // sample counter width
  localparam int unsigned COUNT_WIDTH = 20;

  localparam int unsigned SHIFT_W   = 5;
  localparam int unsigned GAIN_W    = 8;
  localparam int unsigned LEVEL_W   = 16;
  localparam int unsigned SILENT_W  = 8;
  localparam int unsigned SAMPLES_W = 20;
  localparam int unsigned RAW_W     = 32;
  localparam int unsigned OUT_W     = 16;
  localparam int unsigned PROD_W    = RAW_W + GAIN_W + 1;
  localparam int unsigned CMP_W     = (COUNT_WIDTH > SAMPLES_W) ? COUNT_WIDTH : SAMPLES_W;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RIGHT_SHIFT       = 3'd0,
    CFG_GAIN              = 3'd1,
    CFG_SILENCE_LEVEL     = 3'd2,
    CFG_MAX_SILENT_BLOCKS = 3'd3,
    CFG_MIN_SAMPLES       = 3'd4,
    CFG_MAX_SAMPLES       = 3'd5
  } cfg_idx_e;

  localparam logic [SHIFT_W-1:0]   RST_RIGHT_SHIFT   = 5'd14;
  localparam logic [GAIN_W-1:0]    RST_GAIN          = 8'd10;
  localparam logic [LEVEL_W-1:0]   RST_SILENCE_LEVEL = 16'd1500;
  localparam logic [SILENT_W-1:0]  RST_MAX_SILENT    = 8'd60;
  localparam logic [SAMPLES_W-1:0] RST_MIN_SAMPLES   = 20'd16000;
  localparam logic [SAMPLES_W-1:0] RST_MAX_SAMPLES   = 20'd238976;

  localparam logic signed [PROD_W-1:0] PROD_SAT_HIGH = 41'sd32767;
  localparam logic signed [PROD_W-1:0] PROD_SAT_LOW  = -41'sd32768;
  localparam logic signed [OUT_W-1:0]  SAT_HIGH      = 16'sh7fff;
  localparam logic signed [OUT_W-1:0]  SAT_LOW       = 16'sh8000;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX  = '1;
  localparam logic [SILENT_W-1:0]    SILENT_MAX = '1;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw_sample;
    logic                    block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] sample_out;
    logic                    clipped;
    logic                    block_silent;
    logic                    done_res;
  } out_item_t;

endpackage

/* rtl/core/mic_sample_gain_silence_stop.sv */
// ----------------------------------------------------------------------------
// mic_sample_gain_silence_stop
// Shift, gain and 16-bit saturation of microphone samples, with block peak
// tracking, silent block run count and recording stop detection.
// ----------------------------------------------------------------------------
// Path: an accepted item goes to the input register, then to the result
// register once the result register is empty or not stalled.
// Throughput: one item per cycle while the output is not stalled; the state
// update for an item is done combinationally between the two registers.
// Reset: asynchronous, active low; clears both valid flags, the sample count,
// block peak and silent run, and loads the register reset values.
module mic_sample_gain_silence_stop (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  micgs_pkg::in_item_t                   in_item_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output micgs_pkg::out_item_t                  out_item_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [micgs_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [micgs_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import micgs_pkg::*;

  logic [SHIFT_W-1:0]     cfg_shift_q;
  logic [GAIN_W-1:0]      cfg_gain_q;
  logic [LEVEL_W-1:0]     cfg_level_q;
  logic [SILENT_W-1:0]    cfg_max_silent_q;
  logic [SAMPLES_W-1:0]   cfg_min_q;
  logic [SAMPLES_W-1:0]   cfg_max_q;

  logic                   s1_valid_q, s1_valid_d;
  in_item_t               s1_item_q;
  logic                   out_valid_q, out_valid_d;
  out_item_t              out_item_q, out_item_d;

  logic [COUNT_WIDTH-1:0] count_q, count_d, count_inc;
  logic [LEVEL_W-1:0]     peak_q, peak_d, peak_new;
  logic [SILENT_W-1:0]    run_q, run_d, run_new;

  logic                   in_acc, out_ready, advance;
  logic signed [RAW_W-1:0]  shifted;
  logic signed [PROD_W-1:0] prod;
  logic signed [OUT_W-1:0]  sat;
  logic                   clip;
  logic [OUT_W-1:0]       mag;
  logic                   silent, done_max, done_sil, done;

  // handshake
  assign out_ready   = !out_valid_q || !out_stall_i;
  assign advance     = s1_valid_q && out_ready;
  assign in_stall_o  = s1_valid_q && !out_ready;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = advance || (out_valid_q && out_stall_i);
  end

  // conditioning
  always_comb begin
    shifted = s1_item_q.raw_sample >>> cfg_shift_q;
    prod    = shifted * $signed({1'b0, cfg_gain_q});
    clip    = 1'b0;
    sat     = prod[OUT_W-1:0];
    priority if (prod > PROD_SAT_HIGH) begin
      sat  = SAT_HIGH;
      clip = 1'b1;
    end else if (prod < PROD_SAT_LOW) begin
      sat  = SAT_LOW;
      clip = 1'b1;
    end else begin
      sat  = prod[OUT_W-1:0];
    end
    // magnitude of the most negative value wraps to 0x8000, which is 32768
    mag = sat[OUT_W-1] ? (~sat + 1'b1) : sat;
  end

  // block and recording state
  always_comb begin
    peak_new  = (mag > peak_q) ? mag : peak_q;
    count_inc = (count_q != COUNT_MAX) ? count_q + 1'b1 : count_q;
    done_max  = CMP_W'(count_inc) >= CMP_W'(cfg_max_q);
    silent    = 1'b0;
    run_new   = run_q;
    done_sil  = 1'b0;
    if (s1_item_q.block_end) begin
      if (peak_new < cfg_level_q) begin
        silent  = 1'b1;
        run_new = (run_q != SILENT_MAX) ? run_q + 1'b1 : run_q;
      end else begin
        run_new = '0;
      end
      done_sil = (CMP_W'(count_inc) > CMP_W'(cfg_min_q)) && (run_new > cfg_max_silent_q);
    end
    done = done_max || done_sil;

    count_d = count_q;
    peak_d  = peak_q;
    run_d   = run_q;
    if (advance) begin
      if (done) begin
        count_d = '0;
        peak_d  = '0;
        run_d   = '0;
      end else begin
        count_d = count_inc;
        peak_d  = s1_item_q.block_end ? '0 : peak_new;
        run_d   = run_new;
      end
    end

    out_item_d.sample_out   = sat;
    out_item_d.clipped      = clip;
    out_item_d.block_silent = silent;
    out_item_d.done_res     = done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      peak_q      <= '0;
      run_q       <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      peak_q      <= peak_d;
      run_q       <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_shift_q      <= RST_RIGHT_SHIFT;
      cfg_gain_q       <= RST_GAIN;
      cfg_level_q      <= RST_SILENCE_LEVEL;
      cfg_max_silent_q <= RST_MAX_SILENT;
      cfg_min_q        <= RST_MIN_SAMPLES;
      cfg_max_q        <= RST_MAX_SAMPLES;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_RIGHT_SHIFT:       cfg_shift_q      <= cfg_data_i[SHIFT_W-1:0];
        CFG_GAIN:              cfg_gain_q       <= cfg_data_i[GAIN_W-1:0];
        CFG_SILENCE_LEVEL:     cfg_level_q      <= cfg_data_i[LEVEL_W-1:0];
        CFG_MAX_SILENT_BLOCKS: cfg_max_silent_q <= cfg_data_i[SILENT_W-1:0];
        CFG_MIN_SAMPLES:       cfg_min_q        <= cfg_data_i[SAMPLES_W-1:0];
        CFG_MAX_SAMPLES:       cfg_max_q        <= cfg_data_i[SAMPLES_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* rtl/core/micgs_checker.sv */
// ----------------------------------------------------------------------------
// micgs_checker
// Port-level assertions for mic_sample_gain_silence_stop, bound to the top.
// ----------------------------------------------------------------------------
module micgs_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input micgs_pkg::out_item_t out_item_o
);
  import micgs_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result item changed");

  // only a waiting result can push back on the input
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  // saturated samples sit at a rail
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.clipped |->
      (out_item_o.sample_out == SAT_HIGH) || (out_item_o.sample_out == SAT_LOW))
    else $error("clipped item not at a saturation rail");

  // an accepted item comes out when the waiting result is not stalled behind it
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o ##1 !out_stall_i |=> out_valid_o)
    else $error("result item missing after two cycles");

endmodule

bind mic_sample_gain_silence_stop micgs_checker u_micgs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

/* dv/tb_mic_sample_gain_silence_stop.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mic_sample_gain_silence_stop
// Self-checking bench for the microphone sample conditioning block. Every
// accepted item runs through a local copy of the shift, gain, saturation and
// silence-stop logic, and each result is compared field by field, in order.
// A short table of hand-picked items comes first, then randomised read
// blocks under a series of register settings, with bursty input and a
// patterned output stall.
// ----------------------------------------------------------------------------
module tb_mic_sample_gain_silence_stop;
  import micgs_pkg::*;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  // one row of the hand-picked table; want_* is used only when typed is set
  typedef struct packed {
    logic [RAW_W-1:0]        raw;
    logic                    block_end;
    logic                    typed;
    logic signed [OUT_W-1:0] want_sample;
    logic                    want_clip;
    logic                    want_silent;
    logic                    want_done;
  } table_row_t;

  localparam int unsigned NUM_ROWS = 24;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  in_item_t               in_item_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  out_item_t              out_item_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  // register copies
  logic [SHIFT_W-1:0]     cfg_shift;
  logic [GAIN_W-1:0]      cfg_gain;
  logic [LEVEL_W-1:0]     cfg_level;
  logic [SILENT_W-1:0]    cfg_max_silent;
  logic [SAMPLES_W-1:0]   cfg_min_samples;
  logic [SAMPLES_W-1:0]   cfg_max_samples;

  // recording state
  logic [COUNT_WIDTH-1:0] rec_count;
  logic [OUT_W:0]         blk_peak;
  logic [SILENT_W-1:0]    quiet_run;

  out_item_t pending_results[$];
  int        mismatches;
  int        burst_left;

  table_row_t sample_table [NUM_ROWS] = '{
    // reset settings: shift 14, gain 10, level 1500
    '{32'h0000_0000, 1'b0, 1'b1, 16'sh0000, 1'b0, 1'b0, 1'b0},
    '{32'h7fff_ffff, 1'b0, 1'b1, 16'sh7fff, 1'b1, 1'b0, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b1, 16'sh8000, 1'b1, 1'b0, 1'b0},
    // peak of -32768 counts as 32768
    '{32'h8000_0000, 1'b1, 1'b1, 16'sh8000, 1'b1, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b1, 1'b1, 16'sh0000, 1'b0, 1'b1, 1'b0},
    '{32'hffff_ffff, 1'b0, 1'b1, 16'shfff6, 1'b0, 1'b0, 1'b0},
    '{32'h0000_3fff, 1'b0, 1'b0, 16'sh0000, 1'b0, 1'b0, 1'b0},
    '{32'hffff_c000, 1'b0, 1'b0, 16'sh0000, 1'b0, 1'b0, 1'b0},
    '{32'hffff_c001, 1'b0, 1'b0, 16'sh0000, 1'b0, 1'b0, 1'b0},
    '{32'h0000_4000, 1'b0, 1'b0, 16'sh0000, 1'b0, 1'b0, 1'b0},
    // block end item sets the peak right at the level
    '{32'h0025_8000, 1'b1, 1'b0, 16'sh0000, 1'b0, 1'b0, 1'b0},
    '{32'h0025_4000, 1'b1, 1'b0, 16'sh0000, 1'b0, 1'b0, 1'b0},
    '{32'hffda_8000, 1'b1, 1'b0, 16'sh0000, 1'b0, 1'b0, 1'b0},
    // just inside and just past saturation, both signs
    '{32'h0333_0000, 1'b0, 1'b0, 16'sh0000, 1'b0, 1'b0, 1'b0},
    '{32'h0333_4000, 1'b0, 1'b0, 16'sh0000, 1'b0, 1'b0, 1'b0},
    '{32'hfccd_0000, 1'b0, 1'b0, 16'sh0000, 1'b0, 1'b0, 1'b0},
    '{32'hfccc_c000, 1'b1, 1'b0, 16'sh0000, 1'b0, 1'b0, 1'b0},
    // run of quiet blocks
    '{32'h0000_0000, 1'b1, 1'b0, 16'sh0000, 1'b0, 1'b0, 1'b0},
    '{32'h0000_1000, 1'b1, 1'b0, 16'sh0000, 1'b0, 1'b0, 1'b0},
    '{32'hffff_0000, 1'b1, 1'b0, 16'sh0000, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b0, 16'sh0000, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0000, 1'b1, 1'b0, 16'sh0000, 1'b0, 1'b0, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b0, 16'sh0000, 1'b0, 1'b0, 1'b0},
    '{32'haaaa_aaaa, 1'b1, 1'b0, 16'sh0000, 1'b0, 1'b0, 1'b0}
  };

  mic_sample_gain_silence_stop dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t ns: %s", $realtime, msg);
  endtask

  // conditions one sample and advances the recording state
  function automatic out_item_t condition_sample(input in_item_t it);
    logic signed [RAW_W-1:0] shifted;
    longint                  g;
    longint                  prod;
    longint                  mag;
    logic                    done;
    out_item_t               r;
    shifted = $signed(it.raw_sample) >>> cfg_shift;
    g = cfg_gain;
    prod = longint'(shifted) * g;
    r = '0;
    if (prod > 32767) begin
      prod = 32767;
      r.clipped = 1'b1;
    end
    if (prod < -32768) begin
      prod = -32768;
      r.clipped = 1'b1;
    end
    r.sample_out = prod[OUT_W-1:0];
    mag = (prod < 0) ? -prod : prod;
    if (mag > blk_peak) blk_peak = mag[OUT_W:0];
    if (rec_count != '1) rec_count++;
    done = (rec_count >= cfg_max_samples);
    if (it.block_end) begin
      if (blk_peak < cfg_level) begin
        r.block_silent = 1'b1;
        if (quiet_run != '1) quiet_run++;
      end else begin
        quiet_run = '0;
      end
      blk_peak = '0;
      if (rec_count > cfg_min_samples && quiet_run > cfg_max_silent) done = 1'b1;
    end
    // done item reports from the old state, then the recording restarts
    if (done) begin
      rec_count = '0;
      blk_peak  = '0;
      quiet_run = '0;
    end
    r.done_res = done;
    return r;
  endfunction

  // sender: bursts of random length with random gaps in front of them
  task automatic send_item(input logic [RAW_W-1:0] raw, input logic blk_end,
                           input logic typed, input out_item_t want);
    in_item_t  it;
    out_item_t predicted;
    int        gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
    end
    burst_left--;
    it.raw_sample = raw;
    it.block_end  = blk_end;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predicted = condition_sample(it);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk_i);
  endtask

  // leaves valid high so back-to-back writes need no re-raise
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_RIGHT_SHIFT:       cfg_shift       = data[SHIFT_W-1:0];
      CFG_GAIN:              cfg_gain        = data[GAIN_W-1:0];
      CFG_SILENCE_LEVEL:     cfg_level       = data[LEVEL_W-1:0];
      CFG_MAX_SILENT_BLOCKS: cfg_max_silent  = data[SILENT_W-1:0];
      CFG_MIN_SAMPLES:       cfg_min_samples = data[SAMPLES_W-1:0];
      CFG_MAX_SAMPLES:       cfg_max_samples = data[SAMPLES_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [SHIFT_W-1:0] sh, input logic [GAIN_W-1:0] g,
                            input logic [LEVEL_W-1:0] lvl, input logic [SILENT_W-1:0] ms,
                            input logic [SAMPLES_W-1:0] mn, input logic [SAMPLES_W-1:0] mx);
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    write_reg(CFG_RIGHT_SHIFT,       CFG_DATA_W'(sh));
    write_reg(CFG_GAIN,              CFG_DATA_W'(g));
    write_reg(CFG_SILENCE_LEVEL,     CFG_DATA_W'(lvl));
    write_reg(CFG_MAX_SILENT_BLOCKS, CFG_DATA_W'(ms));
    write_reg(CFG_MIN_SAMPLES,       CFG_DATA_W'(mn));
    write_reg(CFG_MAX_SAMPLES,       CFG_DATA_W'(mx));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [RAW_W-1:0] pick_raw(input logic quiet);
    logic signed [RAW_W-1:0] w;
    w = $urandom;
    if (quiet) return w >>> $urandom_range(20, 31);
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'h7fff_ffff;
          1:       return 32'h8000_0000;
          2:       return 32'hffff_ffff;
          default: return 32'h0000_0000;
        endcase
      end
      1, 2, 3, 4: return w;
      default:    return w >>> $urandom_range(0, 24);
    endcase
  endfunction

  // read blocks of random length (one item each when every_end is set), each either quiet or loud
  task automatic run_phase(input int n_items, input logic every_end);
    int   blk_len;
    int   pos;
    logic quiet;
    blk_len = 0;
    pos     = 0;
    quiet   = 1'b0;
    repeat (n_items) begin
      if (pos == blk_len) begin
        blk_len = every_end ? 1 : $urandom_range(1, 6);
        quiet   = 1'($urandom_range(0, 1));
        pos     = 0;
      end
      pos++;
      send_item(pick_raw(quiet), pos == blk_len, 1'b0, '0);
    end
    in_valid_i <= 1'b0;
  endtask

  // receiver stall, switching between patterns
  initial begin
    stall_mode_e mode;
    int          mode_left;
    out_stall_i = 1'b0;
    mode        = STALL_NONE;
    mode_left   = 0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode      = stall_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
        default:     out_stall_i <= ((mode_left % 7) < 4);
      endcase
    end
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_item_o.sample_out !== want.sample_out)
          report_mismatch($sformatf("sample_out %0d, want %0d",
                                    out_item_o.sample_out, want.sample_out));
        if (out_item_o.clipped !== want.clipped)
          report_mismatch($sformatf("clipped %b, want %b",
                                    out_item_o.clipped, want.clipped));
        if (out_item_o.block_silent !== want.block_silent)
          report_mismatch($sformatf("block_silent %b, want %b",
                                    out_item_o.block_silent, want.block_silent));
        if (out_item_o.done_res !== want.done_res)
          report_mismatch($sformatf("done_res %b, want %b",
                                    out_item_o.done_res, want.done_res));
      end
    end
  end

  initial begin
    out_item_t want;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_item_i       = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = CFG_RIGHT_SHIFT;
    cfg_data_i      = '0;
    mismatches      = 0;
    burst_left      = 0;
    cfg_shift       = RST_RIGHT_SHIFT;
    cfg_gain        = RST_GAIN;
    cfg_level       = RST_SILENCE_LEVEL;
    cfg_max_silent  = RST_MAX_SILENT;
    cfg_min_samples = RST_MIN_SAMPLES;
    cfg_max_samples = RST_MAX_SAMPLES;
    rec_count       = '0;
    blk_peak        = '0;
    quiet_run       = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NUM_ROWS; i++) begin
      want.sample_out   = sample_table[i].want_sample;
      want.clipped      = sample_table[i].want_clip;
      want.block_silent = sample_table[i].want_silent;
      want.done_res     = sample_table[i].want_done;
      send_item(sample_table[i].raw, sample_table[i].block_end, sample_table[i].typed, want);
    end
    in_valid_i <= 1'b0;

    // zero max count: every item stops the recording
    set_config(5'd0, 8'd255, 16'd0, 8'd0, 20'd0, 20'd0);
    run_phase(12, 1'b0);
    set_config(5'd31, 8'd255, 16'hffff, 8'd0, 20'd0, 20'd1);
    run_phase(12, 1'b0);
    set_config(5'($urandom_range(8, 20)), 8'($urandom_range(1, 255)),
               16'($urandom_range(0, 4000)), 8'($urandom_range(0, 2)),
               20'($urandom_range(0, 15)), 20'($urandom_range(10, 60)));
    run_phase(30, 1'b0);
    // zero gain, every block quiet
    set_config(5'($urandom_range(0, 31)), 8'd0, 16'd1, 8'd1, 20'd2, 20'hfffff);
    run_phase(20, 1'b0);
    // long quiet run with no stop, so the run count saturates
    set_config(5'd20, 8'd1, 16'h8000, 8'hff, 20'hfffff, 20'hfffff);
    run_phase(265, 1'b1);
    set_config(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
               16'($urandom_range(0, 16'hffff)), 8'($urandom_range(0, 3)),
               20'($urandom_range(0, 30)), 20'($urandom_range(1, 80)));
    run_phase(30, 1'b0);
    set_config(5'd14, 8'd10, 16'd1500, 8'd1, 20'd5, 20'd50);
    run_phase(20, 1'b0);

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
